// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define IOU_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define IOU_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/iou_pkg.sv =====
// Types, constants and codes shared by the track table files.
package iou_pkg;

  localparam int MAX_TRACKS_DEF = 16;

  localparam int CoordW = 12;
  localparam int LifeW  = 4;
  localparam int IdW    = 32;
  localparam int CfgW   = 4;
  localparam int CfgIdxW = 2;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] REG_MATCH_TENTHS = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_BIRTH_LIFE   = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_REFRESH_LIFE = 2'd2;

  localparam logic [CfgW-1:0] MATCH_TENTHS_RST = 4'd3;
  localparam logic [CfgW-1:0] BIRTH_LIFE_RST   = 4'd10;
  localparam logic [CfgW-1:0] REFRESH_LIFE_RST = 4'd5;

  // Input commands.
  localparam logic CMD_DETECT    = 1'b0;
  localparam logic CMD_FRAME_END = 1'b1;

  // Result kinds.
  localparam logic [1:0] KIND_ACK   = 2'd0;
  localparam logic [1:0] KIND_TRACK = 2'd1;
  localparam logic [1:0] KIND_EMPTY = 2'd2;

  // Cell operations.
  localparam logic [2:0] OP_HOLD    = 3'd0;
  localparam logic [2:0] OP_RESOLVE = 3'd1;
  localparam logic [2:0] OP_AGE     = 3'd2;
  localparam logic [2:0] OP_SQUEEZE = 3'd3;
  localparam logic [2:0] OP_ROTATE  = 3'd4;

  typedef struct packed {
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic [CoordW-1:0] w;
    logic [CoordW-1:0] h;
  } box_t;

  typedef struct packed {
    logic             valid;
    logic [IdW-1:0]   id;
    box_t             box;
    logic [LifeW-1:0] life;
    logic             hit;
  } slot_t;

  // Broadcast from the sequencer to every cell.
  typedef struct packed {
    logic [2:0]       op;
    box_t             det;
    logic             any_found;
    logic [IdW-1:0]   new_id;
    logic [CfgW-1:0]  birth_life;
    logic [CfgW-1:0]  refresh_life;
    logic [CfgW-1:0]  match_tenths;
  } cell_ctl_t;

endpackage

// ===== hw/rtl/iou_det_if.sv =====
// Channel that carries detection and frame end items into the table.
interface iou_det_if;
  logic                         valid;
  logic                         ready;
  logic                         cmd;
  logic [iou_pkg::CoordW-1:0]   det_x;
  logic [iou_pkg::CoordW-1:0]   det_y;
  logic [iou_pkg::CoordW-1:0]   det_w;
  logic [iou_pkg::CoordW-1:0]   det_h;

  modport source (output valid, cmd, det_x, det_y, det_w, det_h, input ready);
  modport sink (input valid, cmd, det_x, det_y, det_w, det_h, output ready);
endinterface

// ===== hw/rtl/iou_res_if.sv =====
// Channel that carries result items out of the table.
interface iou_res_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   kind;
  logic [iou_pkg::IdW-1:0]      track_id;
  logic                         is_new;
  logic                         dropped;
  logic [iou_pkg::CoordW-1:0]   box_x;
  logic [iou_pkg::CoordW-1:0]   box_y;
  logic [iou_pkg::CoordW-1:0]   box_w;
  logic [iou_pkg::CoordW-1:0]   box_h;
  logic [iou_pkg::LifeW-1:0]    life_left;
  logic                         last;

  modport source (output valid, kind, track_id, is_new, dropped, box_x, box_y, box_w, box_h,
                  life_left, last, input ready);
  modport sink (input valid, kind, track_id, is_new, dropped, box_x, box_y, box_w, box_h,
                life_left, last, output ready);
endinterface

// ===== hw/rtl/iou_cell.sv =====
// One track slot with its own overlap test pipeline and neighbor links.
module iou_cell (
  input  logic               clk,
  input  logic               rst,
  input  iou_pkg::cell_ctl_t ctl,
  input  iou_pkg::slot_t     next_slot,
  input  iou_pkg::slot_t     head_slot,
  input  logic               found_in,
  input  logic               prev_valid,
  input  logic               dead_in,
  output iou_pkg::slot_t     slot,
  output logic               match,
  output logic               found_out,
  output logic               dead_out
);

  logic [iou_pkg::CoordW:0]   ax_end, bx_end, ay_end, by_end;
  logic [iou_pkg::CoordW-1:0] x1, y1;
  logic [iou_pkg::CoordW:0]   x2, y2;
  logic [iou_pkg::CoordW-1:0] ix, iy, ix_next, iy_next;
  logic [2*iou_pkg::CoordW-1:0] inter, area_s, area_d;
  logic [2*iou_pkg::CoordW:0]   uni;
  logic [2*iou_pkg::CoordW+3:0] lhs;
  logic [2*iou_pkg::CoordW+4:0] rhs;
  logic take_match, take_new;

  always_comb begin
    ax_end = {1'b0, slot.box.x} + {1'b0, slot.box.w};
    ay_end = {1'b0, slot.box.y} + {1'b0, slot.box.h};
    bx_end = {1'b0, ctl.det.x} + {1'b0, ctl.det.w};
    by_end = {1'b0, ctl.det.y} + {1'b0, ctl.det.h};
    x1 = (slot.box.x > ctl.det.x) ? slot.box.x : ctl.det.x;
    y1 = (slot.box.y > ctl.det.y) ? slot.box.y : ctl.det.y;
    x2 = (ax_end < bx_end) ? ax_end : bx_end;
    y2 = (ay_end < by_end) ? ay_end : by_end;
    ix_next = (x2 > {1'b0, x1}) ? iou_pkg::CoordW'(x2 - {1'b0, x1}) : '0;
    iy_next = (y2 > {1'b0, y1}) ? iou_pkg::CoordW'(y2 - {1'b0, y1}) : '0;
    uni = {1'b0, area_s} + {1'b0, area_d} - {1'b0, inter};
    lhs = ($bits(lhs))'(inter) * ($bits(lhs))'(10);
    rhs = ($bits(rhs))'(ctl.match_tenths) * ($bits(rhs))'(uni);
  end

  // Overlap test, three register stages; the sequencer waits them out.
  always_ff @(posedge clk) begin
    ix     <= ix_next;
    iy     <= iy_next;
    inter  <= ix * iy;
    area_s <= slot.box.w * slot.box.h;
    area_d <= ctl.det.w * ctl.det.h;
    match  <= ({1'b0, lhs} > rhs);
  end

  assign found_out  = found_in | (slot.valid & match);
  assign dead_out   = dead_in | (slot.valid & (slot.life == '0));
  assign take_match = slot.valid & match & ~found_in;
  assign take_new   = ~slot.valid & prev_valid & ~ctl.any_found;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot <= '0;
    end else begin
      case (ctl.op)
        iou_pkg::OP_RESOLVE: begin
          if (take_match) begin
            slot.box <= ctl.det;
            slot.hit <= 1'b1;
          end else if (take_new) begin
            slot.valid <= 1'b1;
            slot.id    <= ctl.new_id;
            slot.box   <= ctl.det;
            slot.life  <= ctl.birth_life;
            slot.hit   <= 1'b0;
          end
        end
        iou_pkg::OP_AGE: begin
          if (slot.valid) begin
            if (slot.hit) begin
              slot.life <= ctl.refresh_life;
            end else if (slot.life != '0) begin
              slot.life <= slot.life - 1'b1;
            end
          end
          slot.hit <= 1'b0;
        end
        iou_pkg::OP_SQUEEZE: begin
          if (dead_out) begin
            slot <= next_slot;
          end
        end
        iou_pkg::OP_ROTATE: begin
          if (slot.valid) begin
            slot <= next_slot.valid ? next_slot : head_slot;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/iou_track_table_core.sv =====
// Top level of the track table: sequencer, configuration and the row of cells.
//
// The table holds up to MAX_TRACKS tracked boxes in a row of cells, kept in
// creation order as a prefix of the row. A detection item passes the states
// S_IX, S_MUL and S_CMP, in which every cell runs its own three-stage overlap
// test (intersection, products, threshold compare) against the broadcast box
// in parallel; then S_RES, once the output register is free, picks the first
// matching cell through a ripple chain, updates it or appends a new track (a
// full table drops the detection), and loads the result register. A frame end
// item ages all cells at once, then removes expired tracks one per cycle by
// shifting the cells above down, then reports the survivors one per cycle
// while the output is not stalled, by rotating the live prefix past cell
// zero, or gives one empty result if none are left. One item is processed
// at a time; the next is accepted once the previous one has placed its last
// result in the output register, which may still be waiting for the consumer.
module iou_track_table_core #(
  parameter int MAX_TRACKS = iou_pkg::MAX_TRACKS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [iou_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [iou_pkg::CfgW-1:0]      cfg_data,
  iou_det_if.sink                       det,
  iou_res_if.source                     res
);

  localparam int CntW = $clog2(MAX_TRACKS);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_IX   = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_CMP  = 3'd3;
  localparam logic [2:0] S_RES  = 3'd4;
  localparam logic [2:0] S_AGE  = 3'd5;
  localparam logic [2:0] S_SQZ  = 3'd6;
  localparam logic [2:0] S_RPT  = 3'd7;

  logic [2:0] state, state_next;
  logic [CntW-1:0] cnt;
  logic [CntW-1:0] last_idx;
  logic [iou_pkg::CfgW-1:0] match_tenths, birth_life, refresh_life;
  logic [iou_pkg::IdW-1:0]  next_id;
  iou_pkg::box_t det_box;

  iou_pkg::cell_ctl_t ctl;
  iou_pkg::slot_t     slots [MAX_TRACKS];
  iou_pkg::slot_t     nexts [MAX_TRACKS];
  logic [MAX_TRACKS-1:0] match, found_in, found_out, dead_in, dead_out, prev_valid;

  logic out_free, accept, any_found, full, rpt_last;
  logic [iou_pkg::IdW-1:0]   sel_id;
  logic [iou_pkg::LifeW-1:0] sel_life;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      match_tenths <= iou_pkg::MATCH_TENTHS_RST;
      birth_life   <= iou_pkg::BIRTH_LIFE_RST;
      refresh_life <= iou_pkg::REFRESH_LIFE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        iou_pkg::REG_MATCH_TENTHS: match_tenths <= cfg_data;
        iou_pkg::REG_BIRTH_LIFE:   birth_life   <= cfg_data;
        iou_pkg::REG_REFRESH_LIFE: refresh_life <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Neighbor links: first-match ripple, first-free detect and removal ripple.
  always_comb begin
    for (int i = 0; i < MAX_TRACKS; i++) begin
      found_in[i]   = (i == 0) ? 1'b0 : found_out[(i == 0) ? 0 : i-1];
      dead_in[i]    = (i == 0) ? 1'b0 : dead_out[(i == 0) ? 0 : i-1];
      prev_valid[i] = (i == 0) ? 1'b1 : slots[(i == 0) ? 0 : i-1].valid;
      nexts[i]      = (i == MAX_TRACKS-1) ? '0 : slots[(i == MAX_TRACKS-1) ? i : i+1];
    end
  end

  assign any_found = found_out[MAX_TRACKS-1];
  assign full      = slots[MAX_TRACKS-1].valid;

  // The matched cell is one-hot, so its fields are merged by OR.
  always_comb begin
    sel_id   = '0;
    sel_life = '0;
    for (int i = 0; i < MAX_TRACKS; i++) begin
      if (slots[i].valid && match[i] && !found_in[i]) begin
        sel_id   = sel_id | slots[i].id;
        sel_life = sel_life | slots[i].life;
      end
    end
  end

  // Index of the highest live cell. Rotation keeps the live prefix intact, so
  // this stays fixed while the survivors are reported.
  always_comb begin
    last_idx = '0;
    for (int i = 0; i < MAX_TRACKS; i++) begin
      if (slots[i].valid) begin
        last_idx = CntW'(i);
      end
    end
  end

  for (genvar g = 0; g < MAX_TRACKS; g++) begin : g_cell
    iou_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .next_slot  (nexts[g]),
      .head_slot  (slots[0]),
      .found_in   (found_in[g]),
      .prev_valid (prev_valid[g]),
      .dead_in    (dead_in[g]),
      .slot       (slots[g]),
      .match      (match[g]),
      .found_out  (found_out[g]),
      .dead_out   (dead_out[g])
    );
  end

  assign out_free  = ~res.valid | res.ready;
  assign det.ready = (state == S_IDLE);
  assign accept    = det.valid & det.ready;
  assign rpt_last  = (cnt == last_idx);

  always_comb begin
    ctl.det          = det_box;
    ctl.any_found    = any_found;
    ctl.new_id       = next_id;
    ctl.birth_life   = birth_life;
    ctl.refresh_life = refresh_life;
    ctl.match_tenths = match_tenths;
    ctl.op           = iou_pkg::OP_HOLD;
    state_next       = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = (det.cmd == iou_pkg::CMD_FRAME_END) ? S_AGE : S_IX;
        end
      end
      S_IX:  state_next = S_MUL;
      S_MUL: state_next = S_CMP;
      S_CMP: state_next = S_RES;
      S_RES: begin
        if (out_free) begin
          ctl.op     = iou_pkg::OP_RESOLVE;
          state_next = S_IDLE;
        end
      end
      S_AGE: begin
        ctl.op     = iou_pkg::OP_AGE;
        state_next = S_SQZ;
      end
      S_SQZ: begin
        if (dead_out[MAX_TRACKS-1]) begin
          ctl.op = iou_pkg::OP_SQUEEZE;
        end else begin
          state_next = S_RPT;
        end
      end
      S_RPT: begin
        if (out_free) begin
          if (slots[0].valid) begin
            ctl.op = iou_pkg::OP_ROTATE;
            if (rpt_last) begin
              state_next = S_IDLE;
            end
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      next_id <= '0;
      cnt     <= '0;
    end else begin
      state <= state_next;
      if (state == S_RES && out_free && !any_found && !full) begin
        next_id <= next_id + 1'b1;
      end
      if (state == S_SQZ) begin
        cnt <= '0;
      end else if (ctl.op == iou_pkg::OP_ROTATE) begin
        cnt <= cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      det_box <= '{x: det.det_x, y: det.det_y, w: det.det_w, h: det.det_h};
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (out_free) begin
      res.valid <= (state == S_RES) || (state == S_RPT);
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      res.kind      <= iou_pkg::KIND_ACK;
      res.track_id  <= '0;
      res.is_new    <= 1'b0;
      res.dropped   <= 1'b0;
      res.box_x     <= '0;
      res.box_y     <= '0;
      res.box_w     <= '0;
      res.box_h     <= '0;
      res.life_left <= '0;
      res.last      <= 1'b1;
      if (state == S_RES) begin
        if (any_found) begin
          res.track_id  <= sel_id;
          res.life_left <= sel_life;
          res.box_x <= det_box.x;
          res.box_y <= det_box.y;
          res.box_w <= det_box.w;
          res.box_h <= det_box.h;
        end else if (!full) begin
          res.track_id  <= next_id;
          res.is_new    <= 1'b1;
          res.life_left <= birth_life;
          res.box_x <= det_box.x;
          res.box_y <= det_box.y;
          res.box_w <= det_box.w;
          res.box_h <= det_box.h;
        end else begin
          res.dropped <= 1'b1;
        end
      end else if (state == S_RPT) begin
        if (slots[0].valid) begin
          res.kind      <= iou_pkg::KIND_TRACK;
          res.track_id  <= slots[0].id;
          res.box_x     <= slots[0].box.x;
          res.box_y     <= slots[0].box.y;
          res.box_w     <= slots[0].box.w;
          res.box_h     <= slots[0].box.h;
          res.life_left <= slots[0].life;
          res.last      <= rpt_last;
        end else begin
          res.kind <= iou_pkg::KIND_EMPTY;
        end
      end
    end
  end

endmodule

// ===== hw/rtl/iou_track_table_chk.sv =====
// Port checker for the track table and its bind to the top level.
`include "assert_macros.svh"

module iou_track_table_chk (
  input logic       clk,
  input logic       rst,
  input logic       det_valid,
  input logic       det_ready,
  input logic       res_valid,
  input logic       res_ready,
  input logic [1:0] res_kind,
  input logic       res_is_new,
  input logic       res_dropped,
  input logic       res_last
);

  logic is_ack, is_rpt;

  assign is_ack = res_valid && (res_kind == iou_pkg::KIND_ACK);
  assign is_rpt = res_valid && (res_kind != iou_pkg::KIND_ACK);

  `IOU_ASSERT(a_res_hold, clk, rst, res_valid && !res_ready |=> res_valid, "result dropped while stalled")
  `IOU_ASSERT(a_one_at_a_time, clk, rst, det_valid && det_ready |=> !det_ready, "item accepted while busy")
  `IOU_ASSERT(a_ack_flags, clk, rst, res_valid |-> !(res_is_new && res_dropped), "new and dropped together")
  `IOU_ASSERT(a_report_flags, clk, rst, is_rpt |-> !res_is_new && !res_dropped, "flags on a report")
  `IOU_ASSERT(a_ack_last, clk, rst, is_ack |-> res_last, "acknowledge without last")

endmodule

bind iou_track_table_core iou_track_table_chk u_chk (
  .clk         (clk),
  .rst         (rst),
  .det_valid   (det.valid),
  .det_ready   (det.ready),
  .res_valid   (res.valid),
  .res_ready   (res.ready),
  .res_kind    (res.kind),
  .res_is_new  (res.is_new),
  .res_dropped (res.dropped),
  .res_last    (res.last)
);

// ===== dv/tb.sv =====
// Self-checking testbench for the IOU track table with a built-in table predictor.
`timescale 1ns / 100ps

module tb;

  // One input item as the sender sees it.
  typedef struct {
    logic                       cmd;
    logic [iou_pkg::CoordW-1:0] x;
    logic [iou_pkg::CoordW-1:0] y;
    logic [iou_pkg::CoordW-1:0] w;
    logic [iou_pkg::CoordW-1:0] h;
  } det_item_t;

  // One result item with every field that the monitor compares.
  typedef struct packed {
    logic [1:0]                 kind;
    logic [iou_pkg::IdW-1:0]    id;
    logic                       is_new;
    logic                       dropped;
    logic [iou_pkg::CoordW-1:0] x;
    logic [iou_pkg::CoordW-1:0] y;
    logic [iou_pkg::CoordW-1:0] w;
    logic [iou_pkg::CoordW-1:0] h;
    logic [iou_pkg::LifeW-1:0]  life;
    logic                       last;
  } track_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [iou_pkg::CfgIdxW-1:0] cfg_index = iou_pkg::REG_MATCH_TENTHS;
  logic [iou_pkg::CfgW-1:0] cfg_data = '0;

  iou_det_if det ();
  iou_res_if res ();

  iou_track_table_core u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .det       (det.sink),
    .res       (res.source)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Mirror of the table contents and registers, kept in step with accepted items.
  logic                      tbl_valid [iou_pkg::MAX_TRACKS_DEF];
  logic [iou_pkg::IdW-1:0]   tbl_id    [iou_pkg::MAX_TRACKS_DEF];
  iou_pkg::box_t             tbl_box   [iou_pkg::MAX_TRACKS_DEF];
  logic [iou_pkg::LifeW-1:0] tbl_life  [iou_pkg::MAX_TRACKS_DEF];
  logic                      tbl_hit   [iou_pkg::MAX_TRACKS_DEF];
  logic [iou_pkg::IdW-1:0]   id_next;
  logic [iou_pkg::CfgW-1:0]  thr_tenths;
  logic [iou_pkg::CfgW-1:0]  life_birth;
  logic [iou_pkg::CfgW-1:0]  life_refresh;

  det_item_t  pending_items[$];
  track_res_t expected_results[$];
  int         fail_count = 0;

  // Exact overlap test: intersection*10 > tenths*union.
  function automatic bit overlaps(iou_pkg::box_t a, iou_pkg::box_t b);
    longint x1, y1, x2, y2, iw, ih, inter, uni;
    x1 = (a.x > b.x) ? a.x : b.x;
    y1 = (a.y > b.y) ? a.y : b.y;
    x2 = ((a.x + 0) + longint'(a.w) < longint'(b.x) + b.w) ? longint'(a.x) + a.w
                                                          : longint'(b.x) + b.w;
    y2 = (longint'(a.y) + a.h < longint'(b.y) + b.h) ? longint'(a.y) + a.h
                                                    : longint'(b.y) + b.h;
    iw = (x2 > x1) ? x2 - x1 : 0;
    ih = (y2 > y1) ? y2 - y1 : 0;
    inter = iw * ih;
    uni = longint'(a.w) * a.h + longint'(b.w) * b.h - inter;
    return inter * 10 > longint'(thr_tenths) * uni;
  endfunction

  function automatic track_res_t make_res(logic [1:0] kind, logic [iou_pkg::IdW-1:0] id,
                                          logic nw, logic drop, iou_pkg::box_t b,
                                          logic [iou_pkg::LifeW-1:0] life);
    track_res_t r;
    r.kind = kind; r.id = id; r.is_new = nw; r.dropped = drop;
    r.x = b.x; r.y = b.y; r.w = b.w; r.h = b.h;
    r.life = life; r.last = 1'b0;
    return r;
  endfunction

  // Applies one accepted item to the mirror and queues the results it causes.
  task automatic predict_table(det_item_t it);
    iou_pkg::box_t d;
    int count, wr;
    logic [iou_pkg::LifeW-1:0] lf;
    track_res_t r;
    bit found;
    d.x = it.x; d.y = it.y; d.w = it.w; d.h = it.h;
    if (it.cmd == iou_pkg::CMD_DETECT) begin
      count = 0;
      found = 0;
      for (int i = 0; i < iou_pkg::MAX_TRACKS_DEF; i++) begin
        if (!tbl_valid[i] || found) break;
        count++;
        if (overlaps(d, tbl_box[i])) begin
          found = 1;
          tbl_box[i] = d;
          tbl_hit[i] = 1'b1;
          r = make_res(iou_pkg::KIND_ACK, tbl_id[i], 1'b0, 1'b0, d, tbl_life[i]);
        end
      end
      if (!found) begin
        if (count < iou_pkg::MAX_TRACKS_DEF) begin
          tbl_valid[count] = 1'b1;
          tbl_id[count] = id_next;
          tbl_box[count] = d;
          tbl_life[count] = life_birth;
          tbl_hit[count] = 1'b0;
          r = make_res(iou_pkg::KIND_ACK, id_next, 1'b1, 1'b0, d, life_birth);
          id_next = id_next + 1'b1;
        end else begin
          r = make_res(iou_pkg::KIND_ACK, '0, 1'b0, 1'b1, '0, '0);
        end
      end
      r.last = 1'b1;
      expected_results.insert(expected_results.size(), r);
    end else begin
      // Age every live track, squeeze out the expired ones, report the rest.
      wr = 0;
      for (int i = 0; i < iou_pkg::MAX_TRACKS_DEF; i++) begin
        if (tbl_valid[i]) begin
          if (tbl_hit[i]) lf = life_refresh;
          else lf = (tbl_life[i] != 0) ? tbl_life[i] - 1'b1 : '0;
          if (lf != 0) begin
            tbl_id[wr] = tbl_id[i];
            tbl_box[wr] = tbl_box[i];
            tbl_life[wr] = lf;
            wr++;
          end
        end
      end
      for (int i = 0; i < iou_pkg::MAX_TRACKS_DEF; i++) begin
        tbl_valid[i] = (i < wr);
        tbl_hit[i] = 1'b0;
      end
      for (int i = 0; i < wr; i++)
        expected_results.insert(expected_results.size(),
                                make_res(iou_pkg::KIND_TRACK, tbl_id[i], 1'b0, 1'b0,
                                         tbl_box[i], tbl_life[i]));
      if (wr == 0)
        expected_results.insert(expected_results.size(),
                                make_res(iou_pkg::KIND_EMPTY, '0, 1'b0, 1'b0, '0, '0));
      expected_results[expected_results.size() - 1].last = 1'b1;
    end
  endtask

  // Sender: bursts of random length separated by random gaps.
  det_item_t cur_item;
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin
    logic load;
    if (rst) begin
      det.valid <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      if (det.valid && det.ready) predict_table(cur_item);
      load = !det.valid || det.ready;
      if (load) begin
        if (gap_left > 0 || pending_items.size() == 0) begin
          det.valid <= 1'b0;
          if (gap_left > 0) gap_left <= gap_left - 1;
        end else begin
          cur_item = pending_items.pop_front();
          det.valid <= 1'b1;
          det.cmd <= cur_item.cmd;
          det.det_x <= cur_item.x;
          det.det_y <= cur_item.y;
          det.det_w <= cur_item.w;
          det.det_h <= cur_item.h;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 8);
            // A third of the bursts run straight into the next one.
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end
      end
    end
  end

  // Receiver: stall pattern redrawn at random by stall_tick among open, random and periodic.
  int stall_mode = 0;
  int stall_tick = 0;

  always @(posedge clk) begin
    if (rst) begin
      res.ready <= 1'b0;
      stall_tick <= 0;
    end else begin
      stall_tick <= stall_tick + 1;
      if (stall_tick % 64 == 63) stall_mode <= $urandom_range(0, 2);
      case (stall_mode)
        0: res.ready <= 1'b1;
        1: res.ready <= ($urandom_range(0, 1) == 1);
        default: res.ready <= (stall_tick % 5) < 2;
      endcase
    end
  end

  // Monitor: each accepted result against the oldest expectation.
  always @(posedge clk) begin
    track_res_t act, exp_r;
    if (!rst && res.valid && res.ready) begin
      act.kind = res.kind; act.id = res.track_id; act.is_new = res.is_new;
      act.dropped = res.dropped; act.x = res.box_x; act.y = res.box_y;
      act.w = res.box_w; act.h = res.box_h; act.life = res.life_left; act.last = res.last;
      if (expected_results.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected result, actual %p", $time, act);
      end else begin
        exp_r = expected_results.pop_front();
        if (act !== exp_r) begin
          fail_count++;
          $display("%0t: mismatch, expected %p, actual %p", $time, exp_r, act);
        end
      end
    end
  end

  // Register write through the configuration port; the mirror follows it.
  task automatic write_reg(logic [iou_pkg::CfgIdxW-1:0] idx, logic [iou_pkg::CfgW-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      iou_pkg::REG_MATCH_TENTHS: thr_tenths = val;
      iou_pkg::REG_BIRTH_LIFE:   life_birth = val;
      default:                   life_refresh = val;
    endcase
  endtask

  // Waits until every queued item has been taken and every result seen.
  // Sampled on the falling edge so that the sender's updates have settled.
  task automatic drain_all();
    while (pending_items.size() != 0 || det.valid || expected_results.size() != 0)
      @(negedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic det_item_t box_item(int x, int y, int w, int h);
    det_item_t it;
    it.cmd = iou_pkg::CMD_DETECT;
    it.x = iou_pkg::CoordW'(x); it.y = iou_pkg::CoordW'(y);
    it.w = iou_pkg::CoordW'(w); it.h = iou_pkg::CoordW'(h);
    return it;
  endfunction

  function automatic int clamp12(int v);
    return (v < 0) ? 0 : (v > 4095) ? 4095 : v;
  endfunction

  // Detections that shadow a live track are the largest share, so matches and
  // refreshes happen often; the rest are fresh boxes, extremes and frame ends.
  function automatic det_item_t random_item();
    det_item_t it;
    int live, k, sel;
    live = 0;
    for (int i = 0; i < iou_pkg::MAX_TRACKS_DEF; i++) if (tbl_valid[i]) live++;
    sel = $urandom_range(0, 99);
    if (sel < 20) begin
      it = box_item(0, 0, 0, 0);
      it.cmd = iou_pkg::CMD_FRAME_END;
      it.x = iou_pkg::CoordW'($urandom); it.y = iou_pkg::CoordW'($urandom);
      it.w = iou_pkg::CoordW'($urandom); it.h = iou_pkg::CoordW'($urandom);
    end else if (sel < 65 && live > 0) begin
      k = $urandom_range(0, live - 1);
      it = box_item(clamp12(int'(tbl_box[k].x) + $urandom_range(0, 8) - 4),
                    clamp12(int'(tbl_box[k].y) + $urandom_range(0, 8) - 4),
                    clamp12(int'(tbl_box[k].w) + $urandom_range(0, 8) - 4),
                    clamp12(int'(tbl_box[k].h) + $urandom_range(0, 8) - 4));
    end else if (sel < 90) begin
      it = box_item($urandom_range(0, 4095), $urandom_range(0, 4095),
                    $urandom_range(1, 300), $urandom_range(1, 300));
    end else begin
      it = box_item($urandom, $urandom, $urandom, $urandom);
    end
    return it;
  endfunction

  int cfg_plan[6][3] = '{'{3, 10, 5}, '{0, 1, 1}, '{10, 15, 15}, '{15, 0, 0},
                         '{5, 3, 2}, '{2, 7, 4}};

  initial begin
    det.valid = 1'b0;
    det.cmd = iou_pkg::CMD_DETECT;
    det.det_x = '0; det.det_y = '0; det.det_w = '0; det.det_h = '0;
    res.ready = 1'b0;
    for (int i = 0; i < iou_pkg::MAX_TRACKS_DEF; i++) begin
      tbl_valid[i] = 1'b0; tbl_id[i] = '0; tbl_box[i] = '0;
      tbl_life[i] = '0; tbl_hit[i] = 1'b0;
    end
    id_next = '0;
    thr_tenths = iou_pkg::MATCH_TENTHS_RST;
    life_birth = iou_pkg::BIRTH_LIFE_RST;
    life_refresh = iou_pkg::REFRESH_LIFE_RST;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed part at reset settings: zero-area boxes (zero union never
    // matches), the far corner, a repeat that matches, then the table filled
    // until a detection is dropped, and frame ends with hits and misses.
    pending_items.insert(pending_items.size(), box_item(0, 0, 0, 0));
    pending_items.insert(pending_items.size(), box_item(0, 0, 0, 0));
    pending_items.insert(pending_items.size(), box_item(4095, 4095, 4095, 4095));
    pending_items.insert(pending_items.size(), box_item(4095, 4095, 4095, 4095));
    for (int i = 0; i < 14; i++)
      pending_items.insert(pending_items.size(), box_item(i * 200, 100, 50, 50));
    pending_items.insert(pending_items.size(), box_item(3500, 3500, 10, 10));
    pending_items.insert(pending_items.size(), box_item(0, 100, 50, 50));
    begin
      det_item_t fe;
      fe = box_item(0, 0, 0, 0);
      fe.cmd = iou_pkg::CMD_FRAME_END;
      pending_items.insert(pending_items.size(), fe);
      pending_items.insert(pending_items.size(), fe);
    end
    drain_all();

    for (int p = 0; p < 6; p++) begin
      write_reg(iou_pkg::REG_MATCH_TENTHS, iou_pkg::CfgW'(cfg_plan[p][0]));
      write_reg(iou_pkg::REG_BIRTH_LIFE, iou_pkg::CfgW'(cfg_plan[p][1]));
      write_reg(iou_pkg::REG_REFRESH_LIFE, iou_pkg::CfgW'(cfg_plan[p][2]));
      // Batches keep the generated boxes close to the live table.
      for (int b = 0; b < 3; b++) begin
        for (int n = 0; n < 6; n++) pending_items.insert(pending_items.size(), random_item());
        while (pending_items.size() != 0) @(posedge clk);
      end
      drain_all();
    end

    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/iou_pkg.sv
hw/rtl/iou_det_if.sv
hw/rtl/iou_res_if.sv
hw/rtl/iou_cell.sv
hw/rtl/iou_track_table_core.sv
hw/rtl/iou_track_table_chk.sv
dv/tb.sv
